### design/vpa_pkg.sv
// Shared types and constants for the variable partition allocator.
`default_nettype none
package vpa_pkg;
  localparam int ADDR_BITS = 16;
  localparam int SIZE_W = ADDR_BITS + 1;
  localparam int PID_W = 4;
  localparam int POS_W = 7;
  localparam int MAX_OWNERS_DEF = 16;
  localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] POOL_LIMIT = SIZE_W'(1) << ADDR_BITS;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_FIT = 3'd1;
  localparam logic [2:0] ST_NO_ID = 3'd2;
  localparam logic [2:0] ST_BAD_ID = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  localparam logic [1:0] POL_BEST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic REG_POOL = 1'b0;
  localparam logic REG_FIT = 1'b1;
  localparam logic FN_ALLOC = 1'b0;

  typedef struct packed {
    logic              func;
    logic [16:0]       request_size;
    logic [PID_W-1:0]  release_pid;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PID_W-1:0]  owner_id;
    logic [15:0]       block_start;
    logic [16:0]       block_size;
  } out_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    len;
  } seg_t;

  typedef enum logic [2:0] {
    OP_HOLD, OP_LOAD, OP_WRITE, OP_REMOVE, OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    seg_t             data;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ASCAN, S_AUPD, S_RLOOK, S_RSCAN, S_RUPD, S_RRM
  } state_t;
endpackage
`default_nettype wire

### design/vpa_cell.sv
// One entry of the free segment chain; shifts to and from its neighbors.
`default_nettype none
module vpa_cell #(
  parameter int IDX = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire vpa_pkg::cell_cmd_t cmd,
  input  wire vpa_pkg::seg_t      below,
  input  wire vpa_pkg::seg_t      above,
  output vpa_pkg::seg_t           q
);
  import vpa_pkg::*;

  localparam logic [POS_W-1:0] ME = POS_W'(IDX);

  seg_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      OP_LOAD: begin
        q_nxt = '0;
        if (IDX == 0) begin
          q_nxt.valid = 1'b1;
          q_nxt.len = cmd.data.len;
        end
      end
      OP_WRITE: begin
        if (cmd.pos == ME) q_nxt = cmd.data;
      end
      OP_REMOVE: begin
        if (ME >= cmd.pos) q_nxt = above;
      end
      OP_INSERT: begin
        if (ME > cmd.pos) q_nxt = below;
        else if (ME == cmd.pos) q_nxt = cmd.data;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      if (IDX == 0) begin
        q_r.valid <= 1'b1;
        q_r.len <= POOL_RESET;
      end
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

### design/variable_partition_allocator_core.sv
// Top level: segment chain, owner table and request sequencer.
`default_nettype none
// Allocator with first, best or worst fit over a chain of MAX_OWNERS+1
// free-segment cells. Requests are taken when start is high and busy low.
// A rejected allocate is answered from the idle state; else the chain is
// scanned one cell per cycle (first fit stops at the first match) and the
// chosen cell is then updated. A rejected release is answered from the idle
// state; else it steps through owner table read, scan for the insert point,
// update, and a remove step when the block merges on both sides. Each
// result shows on out_data for one cycle with out_valid; the receiver
// cannot stall it. A write of pool_size reloads the chain and frees all ids.
module variable_partition_allocator_core #(
  parameter int MAX_OWNERS = vpa_pkg::MAX_OWNERS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire vpa_pkg::in_t   in_data,
  output logic                out_valid,
  output vpa_pkg::out_t       out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vpa_pkg::*;

  localparam int DEPTH = MAX_OWNERS + 1;
  localparam int SIW = $clog2(DEPTH);
  localparam int IDW = $clog2(MAX_OWNERS);
  localparam logic [SIW-1:0] LAST = SIW'(DEPTH - 1);

  state_t state_r, state_nxt;
  logic [SIW-1:0] idx_r, idx_nxt, pick_r, pick_nxt, rd_idx;
  logic pick_ok_r, pick_ok_nxt;
  logic [SIZE_W-1:0] best_r, best_nxt, req_r, req_nxt;
  logic [IDW-1:0] id_r, id_nxt, free_id, pid_idx;
  logic free_ok;
  logic [MAX_OWNERS-1:0] use_r, use_nxt;
  logic [POS_W-1:0] p_r, p_nxt;
  logic prev_adj_r, prev_adj_nxt, next_adj_r, next_adj_nxt, prev_ok_r, prev_ok_nxt;
  logic [SIZE_W-1:0] prev_len_r, prev_len_nxt, next_len_r, next_len_nxt;
  logic [SIZE_W-1:0] prev_end_r, prev_end_nxt;
  logic [ADDR_BITS-1:0] prev_start_r, prev_start_nxt;
  logic [SIZE_W-1:0] pool_r, pool_nxt, pool_v;
  logic [1:0] fit_r, fit_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic cfg_wr, accept, pid_bad, mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_wstart, own_start_r;
  logic [SIZE_W-1:0] mem_wsize, own_len_r, end17, new_len;
  cell_cmd_t cmd;
  seg_t cell_q [DEPTH];
  seg_t rd;

  logic [ADDR_BITS-1:0] mem_start [MAX_OWNERS];
  logic [SIZE_W-1:0] own_len [MAX_OWNERS];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    vpa_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .below ((g == 0) ? seg_t'('0) : cell_q[(g == 0) ? 0 : g - 1]),
      .above ((g == DEPTH - 1) ? seg_t'('0) : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .q     (cell_q[g])
    );
  end

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign accept = start & ~busy;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign pid_idx = IDW'(in_data.release_pid);
  assign pid_bad = (int'(in_data.release_pid) >= MAX_OWNERS) || !use_r[pid_idx];
  assign rd_idx = (state_r == S_AUPD) ? pick_r : idx_r;
  assign rd = cell_q[rd_idx];
  assign end17 = {1'b0, own_start_r} + own_len_r;
  assign new_len = rd.len - req_r;
  assign mem_re = accept && (in_data.func != FN_ALLOC);

  always_comb begin
    prdata = (paddr[2] == REG_POOL) ? {{(32 - SIZE_W){1'b0}}, pool_r} : {30'd0, fit_r};
  end

  always_comb begin
    free_id = '0;
    free_ok = 1'b0;
    for (int i = MAX_OWNERS - 1; i >= 0; i--) begin
      if (!use_r[i]) begin
        free_id = IDW'(i);
        free_ok = 1'b1;
      end
    end
  end

  always_comb begin
    pool_v = pwdata[SIZE_W-1:0];
    if (pool_v == '0) pool_v = SIZE_W'(1);
    if (pool_v > POOL_LIMIT) pool_v = POOL_LIMIT;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == FN_ALLOC) begin
            if (in_data.request_size != '0 && free_ok) state_nxt = S_ASCAN;
          end else if (!pid_bad) begin
            state_nxt = S_RLOOK;
          end
        end
      end
      S_ASCAN: begin
        if (!rd.valid || idx_r == LAST) state_nxt = pick_ok_nxt ? S_AUPD : S_IDLE;
        else if (pick_ok_nxt && fit_r != POL_BEST && fit_r != POL_WORST) state_nxt = S_AUPD;
      end
      S_AUPD:  state_nxt = S_IDLE;
      S_RLOOK: state_nxt = S_RSCAN;
      S_RSCAN: begin
        if (!rd.valid || rd.start > own_start_r || idx_r == LAST) state_nxt = S_RUPD;
      end
      S_RUPD:  state_nxt = (prev_adj_r && next_adj_r) ? S_RRM : S_IDLE;
      S_RRM:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    pick_nxt = pick_r;
    pick_ok_nxt = pick_ok_r;
    best_nxt = best_r;
    req_nxt = req_r;
    id_nxt = id_r;
    use_nxt = use_r;
    p_nxt = p_r;
    prev_adj_nxt = prev_adj_r;
    next_adj_nxt = next_adj_r;
    prev_ok_nxt = prev_ok_r;
    prev_len_nxt = prev_len_r;
    next_len_nxt = next_len_r;
    prev_end_nxt = prev_end_r;
    prev_start_nxt = prev_start_r;
    pool_nxt = pool_r;
    fit_nxt = fit_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_wstart = rd.start;
    mem_wsize = req_r;
    cmd = '0;
    cmd.op = OP_HOLD;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          pick_ok_nxt = 1'b0;
          prev_ok_nxt = 1'b0;
          req_nxt = in_data.request_size;
          if (in_data.func == FN_ALLOC) begin
            id_nxt = free_id;
            if (in_data.request_size == '0 || !free_ok) begin
              out_valid_nxt = 1'b1;
              out_nxt = '0;
              out_nxt.status = (in_data.request_size == '0) ? ST_ZERO : ST_NO_ID;
            end
          end else begin
            id_nxt = pid_idx;
            if (pid_bad) begin
              out_valid_nxt = 1'b1;
              out_nxt = '0;
              out_nxt.status = ST_BAD_ID;
              out_nxt.owner_id = in_data.release_pid;
            end else begin
              use_nxt[pid_idx] = 1'b0;
            end
          end
        end
      end
      S_ASCAN: begin
        if (rd.valid && rd.len >= req_r) begin
          if (!pick_ok_r) begin
            pick_nxt = idx_r;
            best_nxt = rd.len;
            pick_ok_nxt = 1'b1;
          end else if ((fit_r == POL_BEST && rd.len < best_r) ||
                       (fit_r == POL_WORST && rd.len > best_r)) begin
            pick_nxt = idx_r;
            best_nxt = rd.len;
          end
        end
        idx_nxt = idx_r + SIW'(1);
        if ((!rd.valid || idx_r == LAST) && !pick_ok_nxt) begin
          out_valid_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.status = ST_NO_FIT;
        end
      end
      S_AUPD: begin
        mem_we = 1'b1;
        use_nxt[id_r] = 1'b1;
        cmd.pos = POS_W'(pick_r);
        if (new_len == '0) begin
          cmd.op = OP_REMOVE;
        end else begin
          cmd.op = OP_WRITE;
          cmd.data.valid = 1'b1;
          cmd.data.start = rd.start + req_r[ADDR_BITS-1:0];
          cmd.data.len = new_len;
        end
        out_valid_nxt = 1'b1;
        out_nxt.status = ST_OK;
        out_nxt.owner_id = PID_W'(id_r);
        out_nxt.block_start = rd.start;
        out_nxt.block_size = req_r;
      end
      S_RLOOK: begin
        idx_nxt = '0;
      end
      S_RSCAN: begin
        if (!rd.valid || rd.start > own_start_r) begin
          p_nxt = POS_W'(idx_r);
          next_adj_nxt = rd.valid && (end17 == {1'b0, rd.start});
          next_len_nxt = rd.len;
          prev_adj_nxt = prev_ok_r && (prev_end_r == {1'b0, own_start_r});
        end else begin
          prev_end_nxt = {1'b0, rd.start} + rd.len;
          prev_len_nxt = rd.len;
          prev_start_nxt = rd.start;
          prev_ok_nxt = 1'b1;
          idx_nxt = idx_r + SIW'(1);
          if (idx_r == LAST) begin
            p_nxt = POS_W'(DEPTH);
            next_adj_nxt = 1'b0;
            prev_adj_nxt = (prev_end_nxt == {1'b0, own_start_r});
          end
        end
      end
      S_RUPD: begin
        out_nxt.status = ST_OK;
        out_nxt.owner_id = PID_W'(id_r);
        out_nxt.block_start = own_start_r;
        out_nxt.block_size = own_len_r;
        out_valid_nxt = !(prev_adj_r && next_adj_r);
        cmd.data.valid = 1'b1;
        if (prev_adj_r) begin
          cmd.op = OP_WRITE;
          cmd.pos = p_r - POS_W'(1);
          cmd.data.start = prev_start_r;
          cmd.data.len = prev_len_r + own_len_r + (next_adj_r ? next_len_r : '0);
        end else if (next_adj_r) begin
          cmd.op = OP_WRITE;
          cmd.pos = p_r;
          cmd.data.start = own_start_r;
          cmd.data.len = next_len_r + own_len_r;
        end else begin
          cmd.op = cell_q[DEPTH-1].valid ? OP_HOLD : OP_INSERT;
          cmd.pos = p_r;
          cmd.data.start = own_start_r;
          cmd.data.len = own_len_r;
        end
      end
      S_RRM: begin
        cmd.op = OP_REMOVE;
        cmd.pos = p_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase

    if (cfg_wr) begin
      if (paddr[2] == REG_POOL) begin
        pool_nxt = pool_v;
        use_nxt = '0;
        cmd = '0;
        cmd.op = OP_LOAD;
        cmd.data.len = pool_v;
      end else begin
        fit_nxt = pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[id_r] <= mem_wstart;
      own_len[id_r] <= mem_wsize;
    end
    if (mem_re) begin
      own_start_r <= mem_start[pid_idx];
      own_len_r <= own_len[pid_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      use_r <= '0;
      pool_r <= POOL_RESET;
      fit_r <= '0;
      out_valid_r <= 1'b0;
      pick_ok_r <= 1'b0;
      prev_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      use_r <= use_nxt;
      pool_r <= pool_nxt;
      fit_r <= fit_nxt;
      out_valid_r <= out_valid_nxt;
      pick_ok_r <= pick_ok_nxt;
      prev_ok_r <= prev_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    req_r <= req_nxt;
    id_r <= id_nxt;
    p_r <= p_nxt;
    prev_adj_r <= prev_adj_nxt;
    next_adj_r <= next_adj_nxt;
    prev_len_r <= prev_len_nxt;
    next_len_r <= next_len_nxt;
    prev_end_r <= prev_end_nxt;
    prev_start_r <= prev_start_nxt;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire

### design/vpa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
`default_nettype none
module vpa_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input wire vpa_pkg::out_t  out_data
);
  import vpa_pkg::*;

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy at result");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.block_size == '0))
    else $error("failed transaction carries a size");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy) && !$past(start)) |-> 1'b0)
    else $error("busy without a transaction");
endmodule

bind variable_partition_allocator_core vpa_checker u_vpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
